// ----- hdl/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is asserted.
`define PA_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, checked during reset as well.
`define PA_ASSERT_NEXT(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ----- hdl/pa_pkg.sv -----
// Types and constants shared by the primitive assembly modules.
package pa_pkg;

    localparam int VERTEX_BITS_DEF = 16;
    localparam int QUEUE_DEPTH_DEF = 2;

    typedef enum logic [3:0] {
        OP_POINTS     = 4'd0,
        OP_LINE_STRIP = 4'd1,
        OP_LINES      = 4'd2,
        OP_POLYGON    = 4'd3,
        OP_STRIP      = 4'd4,
        OP_FAN        = 4'd5,
        OP_TRIANGLES  = 4'd6,
        OP_STRIP_CONT = 4'd7,
        OP_FAN_CONT   = 4'd8
    } t_op;

    typedef enum logic [2:0] {
        M_POINT,
        M_LINE_STRIP,
        M_LINES,
        M_TRIS,
        M_STRIP,
        M_FAN
    } t_mode;

    typedef enum logic [1:0] {
        KIND_POINT = 2'd0,
        KIND_LINE  = 2'd1,
        KIND_TRI   = 2'd2
    } t_kind;

    typedef struct packed {
        t_mode mode;
        logic  first;
        logic  new_strip;
        logic  new_fan;
    } t_cmd;

    localparam int CMD_BITS = $bits(t_cmd);

endpackage

// ----- hdl/pa_fifo.sv -----
// Small register queue with push/full and pop/empty handshakes.
module pa_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = pa_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);
    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]    r_mem [DEPTH];
    logic [PTR_BITS-1:0] r_wr, n_wr;
    logic [PTR_BITS-1:0] r_rd, n_rd;
    logic [CNT_BITS-1:0] r_count, n_count;
    logic                do_push, do_pop;

    assign o_full  = (r_count == CNT_BITS'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (do_push) begin
            n_wr = (r_wr == PTR_BITS'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == PTR_BITS'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ----- hdl/pa_front.sv -----
// Front end: takes vertex requests, decodes the mode and queues commands.
module pa_front #(
    parameter int VERTEX_BITS = pa_pkg::VERTEX_BITS_DEF,
    parameter int QUEUE_DEPTH = pa_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    output logic                   o_full,
    input  logic [3:0]             i_op,
    input  logic                   i_first,
    input  logic [VERTEX_BITS-1:0] i_vertex,
    output logic                   o_cmd_valid,
    output pa_pkg::t_cmd           o_cmd,
    output logic [VERTEX_BITS-1:0] o_cmd_vertex,
    input  logic                   i_cmd_pop
);
    localparam int QW = pa_pkg::CMD_BITS + VERTEX_BITS;

    pa_pkg::t_cmd  cmd;
    logic          keep;
    logic [QW-1:0] q_data;
    logic          q_empty;

    // Ignored modes are accepted and dropped here; they never reach the back end.
    always_comb begin
        keep          = 1'b1;
        cmd.mode      = pa_pkg::M_POINT;
        cmd.first     = i_first;
        cmd.new_strip = 1'b0;
        cmd.new_fan   = 1'b0;
        case (pa_pkg::t_op'(i_op))
            pa_pkg::OP_POINTS: begin
                cmd.mode = pa_pkg::M_POINT;
            end
            pa_pkg::OP_LINE_STRIP: begin
                cmd.mode = pa_pkg::M_LINE_STRIP;
            end
            pa_pkg::OP_LINES: begin
                cmd.mode = pa_pkg::M_LINES;
            end
            pa_pkg::OP_TRIANGLES: begin
                cmd.mode = pa_pkg::M_TRIS;
            end
            pa_pkg::OP_STRIP: begin
                cmd.mode      = pa_pkg::M_STRIP;
                cmd.new_strip = i_first;
            end
            pa_pkg::OP_STRIP_CONT: begin
                cmd.mode = pa_pkg::M_STRIP;
            end
            pa_pkg::OP_POLYGON, pa_pkg::OP_FAN: begin
                cmd.mode    = pa_pkg::M_FAN;
                cmd.new_fan = i_first;
            end
            pa_pkg::OP_FAN_CONT: begin
                cmd.mode = pa_pkg::M_FAN;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    pa_fifo #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push && keep),
        .i_data  ({cmd, i_vertex}),
        .o_full  (o_full),
        .i_pop   (i_cmd_pop),
        .o_empty (q_empty),
        .o_data  (q_data)
    );

    assign o_cmd_valid  = !q_empty;
    assign o_cmd        = pa_pkg::t_cmd'(q_data[QW-1 -: pa_pkg::CMD_BITS]);
    assign o_cmd_vertex = q_data[VERTEX_BITS-1:0];

endmodule

// ----- hdl/pa_back.sv -----
// Back end: holds the strip, fan and list state and emits primitives.
module pa_back #(
    parameter int VERTEX_BITS = pa_pkg::VERTEX_BITS_DEF,
    parameter int QUEUE_DEPTH = pa_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cmd_valid,
    input  pa_pkg::t_cmd           i_cmd,
    input  logic [VERTEX_BITS-1:0] i_cmd_vertex,
    output logic                   o_cmd_pop,
    output logic                   o_empty,
    input  logic                   i_pop,
    output logic [1:0]             o_kind,
    output logic [VERTEX_BITS-1:0] o_v0,
    output logic [VERTEX_BITS-1:0] o_v1,
    output logic [VERTEX_BITS-1:0] o_v2
);
    localparam int RW = 2 + 3 * VERTEX_BITS;

    logic [1:0]             r_pos, n_pos;
    logic [VERTEX_BITS-1:0] r_held_first, n_held_first;
    logic [VERTEX_BITS-1:0] r_held_second, n_held_second;
    logic [VERTEX_BITS-1:0] r_strip_older, n_strip_older;
    logic [VERTEX_BITS-1:0] r_strip_newer, n_strip_newer;
    logic [1:0]             r_strip_count, n_strip_count;
    logic                   r_strip_rev, n_strip_rev;
    logic [VERTEX_BITS-1:0] r_fan_pivot, n_fan_pivot;
    logic [VERTEX_BITS-1:0] r_fan_last, n_fan_last;
    logic [1:0]             r_fan_count, n_fan_count;

    logic                   out_full;
    logic                   take;
    logic                   emit;
    pa_pkg::t_kind          kind;
    logic [VERTEX_BITS-1:0] e0, e1, e2;
    logic [VERTEX_BITS-1:0] v;
    logic [1:0]             pos, scnt, fcnt;
    logic                   srev;
    logic [RW-1:0]          r_data;

    assign take      = i_cmd_valid && !out_full;
    assign o_cmd_pop = take;
    assign v         = i_cmd_vertex;

    always_comb begin
        n_pos         = r_pos;
        n_held_first  = r_held_first;
        n_held_second = r_held_second;
        n_strip_older = r_strip_older;
        n_strip_newer = r_strip_newer;
        n_strip_count = r_strip_count;
        n_strip_rev   = r_strip_rev;
        n_fan_pivot   = r_fan_pivot;
        n_fan_last    = r_fan_last;
        n_fan_count   = r_fan_count;
        emit          = 1'b0;
        kind          = pa_pkg::KIND_POINT;
        e0            = v;
        e1            = '0;
        e2            = '0;
        pos           = i_cmd.first ? 2'd0 : r_pos;
        scnt          = i_cmd.new_strip ? 2'd0 : r_strip_count;
        srev          = i_cmd.new_strip ? 1'b0 : r_strip_rev;
        fcnt          = i_cmd.new_fan ? 2'd0 : r_fan_count;
        n_pos         = pos;
        case (i_cmd.mode)
            pa_pkg::M_POINT: begin
                emit = 1'b1;
            end
            pa_pkg::M_LINE_STRIP: begin
                n_held_first = v;
                n_pos        = 2'd1;
                if (pos != 2'd0) begin
                    emit = 1'b1;
                    kind = pa_pkg::KIND_LINE;
                    e0   = r_held_first;
                    e1   = v;
                end
            end
            pa_pkg::M_LINES: begin
                if (pos == 2'd0) begin
                    n_held_first = v;
                    n_pos        = 2'd1;
                end else begin
                    n_pos = 2'd0;
                    emit  = 1'b1;
                    kind  = pa_pkg::KIND_LINE;
                    e0    = r_held_first;
                    e1    = v;
                end
            end
            pa_pkg::M_TRIS: begin
                if (pos == 2'd0) begin
                    n_held_first = v;
                    n_pos        = 2'd1;
                end else if (pos == 2'd1) begin
                    n_held_second = v;
                    n_pos         = 2'd2;
                end else begin
                    n_pos = 2'd0;
                    emit  = 1'b1;
                    kind  = pa_pkg::KIND_TRI;
                    e0    = r_held_first;
                    e1    = r_held_second;
                    e2    = v;
                end
            end
            pa_pkg::M_STRIP: begin
                n_strip_rev = srev;
                if (scnt == 2'd0) begin
                    n_strip_older = v;
                    n_strip_count = 2'd1;
                end else if (scnt == 2'd1) begin
                    n_strip_newer = v;
                    n_strip_count = 2'd2;
                end else begin
                    // Every other triangle swaps its first two vertices to keep winding.
                    n_strip_count = scnt;
                    n_strip_older = r_strip_newer;
                    n_strip_newer = v;
                    n_strip_rev   = !srev;
                    emit          = 1'b1;
                    kind          = pa_pkg::KIND_TRI;
                    e0            = srev ? r_strip_newer : r_strip_older;
                    e1            = srev ? r_strip_older : r_strip_newer;
                    e2            = v;
                end
            end
            pa_pkg::M_FAN: begin
                if (fcnt == 2'd0) begin
                    n_fan_pivot = v;
                    n_fan_count = 2'd1;
                end else if (fcnt == 2'd1) begin
                    n_fan_last  = v;
                    n_fan_count = 2'd2;
                end else begin
                    n_fan_count = fcnt;
                    n_fan_last  = v;
                    emit        = 1'b1;
                    kind        = pa_pkg::KIND_TRI;
                    e0          = r_fan_pivot;
                    e1          = r_fan_last;
                    e2          = v;
                end
            end
            default: begin
                n_pos = r_pos;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos         <= '0;
            r_held_first  <= '0;
            r_held_second <= '0;
            r_strip_older <= '0;
            r_strip_newer <= '0;
            r_strip_count <= '0;
            r_strip_rev   <= 1'b0;
            r_fan_pivot   <= '0;
            r_fan_last    <= '0;
            r_fan_count   <= '0;
        end else if (take) begin
            r_pos         <= n_pos;
            r_held_first  <= n_held_first;
            r_held_second <= n_held_second;
            r_strip_older <= n_strip_older;
            r_strip_newer <= n_strip_newer;
            r_strip_count <= n_strip_count;
            r_strip_rev   <= n_strip_rev;
            r_fan_pivot   <= n_fan_pivot;
            r_fan_last    <= n_fan_last;
            r_fan_count   <= n_fan_count;
        end
    end

    pa_fifo #(
        .WIDTH (RW),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (take && emit),
        .i_data  ({kind, e0, e1, e2}),
        .o_full  (out_full),
        .i_pop   (i_pop),
        .o_empty (o_empty),
        .o_data  (r_data)
    );

    assign o_kind = r_data[RW-1 -: 2];
    assign o_v0   = r_data[3*VERTEX_BITS-1 -: VERTEX_BITS];
    assign o_v1   = r_data[2*VERTEX_BITS-1 -: VERTEX_BITS];
    assign o_v2   = r_data[VERTEX_BITS-1:0];

endmodule

// ----- hdl/primitive_assembly.sv -----
// Top level of the primitive assembly block.
//
// Vertex requests enter through a push/full queue, one per cycle while full is low,
// and assembled points, lines and triangles leave through an empty/pop queue. The
// block sustains one vertex per clock while the result queue is not full: the back
// end updates its list, strip and fan registers for one command each such cycle.
// A primitive reaches the result ports through the command queue and then the result
// queue once its last vertex is accepted. Each queue holds QUEUE_DEPTH entries and
// takes no new entry while it is full, even in a cycle where it is popped. While the
// result queue is full the back end stops, also for vertices that emit nothing, and
// full rises once QUEUE_DEPTH requests wait. Vertices with an unknown mode are
// accepted and dropped. Unused vertex fields of points and lines read as zero.
module primitive_assembly #(
    parameter int VERTEX_BITS = pa_pkg::VERTEX_BITS_DEF,
    parameter int QUEUE_DEPTH = pa_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   push,
    output logic                   full,
    input  logic [3:0]             i_op,
    input  logic                   i_first,
    input  logic [VERTEX_BITS-1:0] i_vertex,
    output logic                   empty,
    input  logic                   pop,
    output logic [1:0]             o_kind,
    output logic [VERTEX_BITS-1:0] o_v0,
    output logic [VERTEX_BITS-1:0] o_v1,
    output logic [VERTEX_BITS-1:0] o_v2
);
    logic                   cmd_valid;
    logic                   cmd_pop;
    pa_pkg::t_cmd           cmd;
    logic [VERTEX_BITS-1:0] cmd_vertex;

    pa_front #(
        .VERTEX_BITS (VERTEX_BITS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_op         (i_op),
        .i_first      (i_first),
        .i_vertex     (i_vertex),
        .o_cmd_valid  (cmd_valid),
        .o_cmd        (cmd),
        .o_cmd_vertex (cmd_vertex),
        .i_cmd_pop    (cmd_pop)
    );

    pa_back #(
        .VERTEX_BITS (VERTEX_BITS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (cmd_valid),
        .i_cmd        (cmd),
        .i_cmd_vertex (cmd_vertex),
        .o_cmd_pop    (cmd_pop),
        .o_empty      (empty),
        .i_pop        (pop),
        .o_kind       (o_kind),
        .o_v0         (o_v0),
        .o_v1         (o_v1),
        .o_v2         (o_v2)
    );

endmodule

// ----- hdl/pa_checker.sv -----
// Port-level checks for the primitive assembly block, bound to the top level.
`include "assert_macros.svh"

module pa_checker #(
    parameter int VERTEX_BITS = pa_pkg::VERTEX_BITS_DEF
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   full,
    input logic                   empty,
    input logic                   pop,
    input logic [1:0]             o_kind,
    input logic [VERTEX_BITS-1:0] o_v0,
    input logic [VERTEX_BITS-1:0] o_v1,
    input logic [VERTEX_BITS-1:0] o_v2
);
    logic is_point;
    logic is_line;
    logic is_tri;

    assign is_point = (o_kind == pa_pkg::KIND_POINT);
    assign is_line  = (o_kind == pa_pkg::KIND_LINE);
    assign is_tri   = (o_kind == pa_pkg::KIND_TRI);

    `PA_ASSERT_NEXT(a_reset_clears, i_clk, !i_rst_n, empty && !full)
    `PA_ASSERT_IMPLY(a_kind_known, i_clk, i_rst_n, !empty, is_point || is_line || is_tri)
    `PA_ASSERT_IMPLY(a_point_zero, i_clk, i_rst_n, !empty && is_point, o_v1 == '0 && o_v2 == '0)
    `PA_ASSERT_IMPLY(a_line_zero, i_clk, i_rst_n, !empty && is_line, o_v2 == '0)
    `PA_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n && !empty && !pop,
        !i_rst_n || (!empty && $stable(o_kind) && $stable(o_v0)))

endmodule

bind primitive_assembly pa_checker #(
    .VERTEX_BITS (VERTEX_BITS)
) u_pa_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .full    (full),
    .empty   (empty),
    .pop     (pop),
    .o_kind  (o_kind),
    .o_v0    (o_v0),
    .o_v1    (o_v1),
    .o_v2    (o_v2)
);
